// ===== rtl/tlik_pkg.sv =====
`default_nettype none

package tlik_pkg;

    // Number of CORDIC micro-rotations in each arctangent unit.
    localparam int CORDIC_ITERATIONS = 16;

    // CORDIC datapath: vectors are normalized to a magnitude in [2^40, 2^41).
    localparam int CW = 45;
    // Angle accumulator in units of 2^-16 degree.
    localparam int ZW = 27;
    // Greedy normalization uses shifts of 32, 16, 8, 4, 2 and 1.
    localparam int NORM_STEPS = 6;
    localparam int CORDIC_LAT = CORDIC_ITERATIONS + NORM_STEPS + 2;

    // Integer square root: 60-bit radicand, one root bit per cell.
    localparam int SQ_RAD_W = 60;
    localparam int SQ_ROOT_W = 30;
    localparam int SQ_LAT = SQ_ROOT_W;

    localparam logic signed [ZW-1:0] Z90 = 27'sd5898240;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } t_cordic;

    typedef struct packed {
        logic [SQ_RAD_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } t_sqrt;

    // atan(2^-i) in units of 2^-16 degree, rounded to nearest.
    function automatic logic [21:0] atan_units(input logic [4:0] step);
        logic [21:0] a;
        case (step)
            5'd0:    a = 22'd2949120;
            5'd1:    a = 22'd1740967;
            5'd2:    a = 22'd919879;
            5'd3:    a = 22'd466945;
            5'd4:    a = 22'd234379;
            5'd5:    a = 22'd117304;
            5'd6:    a = 22'd58666;
            5'd7:    a = 22'd29335;
            5'd8:    a = 22'd14668;
            5'd9:    a = 22'd7334;
            5'd10:   a = 22'd3667;
            5'd11:   a = 22'd1833;
            5'd12:   a = 22'd917;
            5'd13:   a = 22'd458;
            5'd14:   a = 22'd229;
            5'd15:   a = 22'd115;
            5'd16:   a = 22'd57;
            5'd17:   a = 22'd29;
            5'd18:   a = 22'd14;
            5'd19:   a = 22'd7;
            5'd20:   a = 22'd4;
            5'd21:   a = 22'd2;
            5'd22:   a = 22'd1;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tlik_sqrt_cell.sv =====
`default_nettype none

module tlik_sqrt_cell (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  wire logic [4:0]     i_step,
    input  tlik_pkg::t_sqrt     i_d,
    output tlik_pkg::t_sqrt     o_d
);
    import tlik_pkg::*;

    t_sqrt            r_d;
    t_sqrt            n_d;
    logic [SQ_RAD_W:0] term;

    // Trying root bit k costs 2^(k+1)*root + 4^k of the remainder.
    always_comb begin
        term = ((SQ_RAD_W + 1)'(i_d.root) << ({1'b0, i_step} + 6'd1))
             + ((SQ_RAD_W + 1)'(1) << {i_step, 1'b0});
        n_d = i_d;
        if ({1'b0, i_d.rem} >= term) begin
            n_d.rem  = SQ_RAD_W'({1'b0, i_d.rem} - term);
            n_d.root = i_d.root | (SQ_ROOT_W'(1) << i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

// ===== rtl/tlik_sqrt.sv =====
`default_nettype none

module tlik_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [tlik_pkg::SQ_RAD_W-1:0] i_rad,
    output logic [tlik_pkg::SQ_ROOT_W-1:0]     o_root
);
    import tlik_pkg::*;

    t_sqrt w [SQ_LAT+1];

    assign w[0].rem  = i_rad;
    assign w[0].root = '0;

    // One cell per root bit, most significant bit first.
    for (genvar j = 0; j < SQ_LAT; j++) begin : g_cell
        tlik_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_step (5'(SQ_LAT - 1 - j)),
            .i_d    (w[j]),
            .o_d    (w[j+1])
        );
    end

    assign o_root = w[SQ_LAT].root;

endmodule

`default_nettype wire

// ===== rtl/tlik_cordic_cell.sv =====
`default_nettype none

module tlik_cordic_cell (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [4:0] i_step,
    input  tlik_pkg::t_cordic i_d,
    output tlik_pkg::t_cordic o_d
);
    import tlik_pkg::*;

    t_cordic              r_d;
    t_cordic              n_d;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] a;

    // Vectoring step: rotate toward the x axis, arithmetic shifts round down.
    always_comb begin
        dx = i_d.y >>> i_step;
        dy = i_d.x >>> i_step;
        a  = ZW'(atan_units(i_step));
        n_d = i_d;
        if (!i_d.y[CW-1]) begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + a;
        end else begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

// ===== rtl/tlik_cordic.sv =====
`default_nettype none

module tlik_cordic (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic signed [tlik_pkg::CW-1:0] i_y,
    input  wire logic signed [tlik_pkg::CW-1:0] i_x,
    output logic signed [tlik_pkg::ZW-1:0]      o_z
);
    import tlik_pkg::*;

    localparam logic [CW-1:0] NORM_LIMIT = CW'(1) << 40;

    logic signed [CW-1:0] r_px;
    logic signed [CW-1:0] r_py;
    logic [CW-1:0]        r_pm;
    logic                 r_pzero;
    logic [CW-1:0]        ax;
    logic [CW-1:0]        ay;

    logic signed [CW-1:0] r_nx [NORM_STEPS];
    logic signed [CW-1:0] r_ny [NORM_STEPS];
    logic [CW-1:0]        r_nm [NORM_STEPS];
    logic                 r_nzero [NORM_STEPS];

    t_cordic              r_q;
    t_cordic              n_q;
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;

    t_cordic w [CORDIC_ITERATIONS+1];

    assign ax = i_x[CW-1] ? CW'(-i_x) : CW'(i_x);
    assign ay = i_y[CW-1] ? CW'(-i_y) : CW'(i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px    <= i_x;
            r_py    <= i_y;
            r_pm    <= (ax > ay) ? ax : ay;
            r_pzero <= (i_x == '0) && (i_y == '0);
        end
    end

    // Greedy normalization: take each shift that keeps the magnitude below 2^40.
    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH = 32 >> j;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic [CW-1:0]        sm;
        logic                 sz;
        if (j == 0) begin : g_first
            assign sx = r_px;
            assign sy = r_py;
            assign sm = r_pm;
            assign sz = r_pzero;
        end else begin : g_next
            assign sx = r_nx[j-1];
            assign sy = r_ny[j-1];
            assign sm = r_nm[j-1];
            assign sz = r_nzero[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (sm < (NORM_LIMIT >> SH)) begin
                    r_nx[j] <= sx <<< SH;
                    r_ny[j] <= sy <<< SH;
                    r_nm[j] <= sm << SH;
                end else begin
                    r_nx[j] <= sx;
                    r_ny[j] <= sy;
                    r_nm[j] <= sm;
                end
                r_nzero[j] <= sz;
            end
        end
    end

    // Last doubling, then a vector in the left half plane turns by 90 degrees.
    always_comb begin
        if (r_nm[NORM_STEPS-1] < NORM_LIMIT) begin
            x1 = r_nx[NORM_STEPS-1] <<< 1;
            y1 = r_ny[NORM_STEPS-1] <<< 1;
        end else begin
            x1 = r_nx[NORM_STEPS-1];
            y1 = r_ny[NORM_STEPS-1];
        end
        n_q.zero = r_nzero[NORM_STEPS-1];
        n_q.x = x1;
        n_q.y = y1;
        n_q.z = '0;
        if (x1[CW-1]) begin
            if (!y1[CW-1]) begin
                n_q.x = y1;
                n_q.y = -x1;
                n_q.z = Z90;
            end else begin
                n_q.x = -y1;
                n_q.y = x1;
                n_q.z = -Z90;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign w[0] = r_q;

    for (genvar j = 0; j < CORDIC_ITERATIONS; j++) begin : g_cell
        tlik_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_step (5'(j)),
            .i_d    (w[j]),
            .o_d    (w[j+1])
        );
    end

    assign o_z = w[CORDIC_ITERATIONS].zero ? '0 : w[CORDIC_ITERATIONS].z;

endmodule

`default_nettype wire

// ===== rtl/two_link_arm_inverse_kinematics_top.sv =====
// Two-link planar arm inverse kinematics with base yaw.
//
// Input words arrive on the slave stream: tuser carries the operation (0 grasp,
// 1 place) and tdata carries point_x, point_y and point_z. Each accepted word
// yields exactly one output word on the master stream: tdata carries the
// shoulder, elbow, wrist and base yaw angles in hundredths of a degree, and
// tuser carries the unreachable flag. The user writes link and tool lengths through
// the plain configuration port only while idle; the block does not enforce it.
//
// The datapath is a fully pipelined row of cells: five front stages of squares
// and products, two 30-cell square root chains (one root bit per cell), four
// parallel CORDIC chains (one micro-rotation per cell) and a rounding stage.
// A word is accepted every cycle while the pipeline does not stall.
//
// An output register backed by a one-word skid stage decouples the sides. The
// whole pipeline stalls only while the skid word is occupied. While the
// receiver stalls, input words are still taken until a finished word has to
// wait in the skid stage; with words back to back that is one more word.
// Reset clears all valid flags and loads lengths of 2000, 1200 and 1300.
`default_nettype none

module two_link_arm_inverse_kinematics_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // point_x [14:0], point_y [29:15], point_z [44:30], zero pad [47:45]
    input  wire logic [47:0] i_s_tdata,
    // operation [0]
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // shoulder_angle [17:0], elbow_angle [35:18], wrist_angle [53:36],
    // base_yaw_angle [69:54], zero pad [71:70]
    output logic [71:0]      o_m_tdata,
    // unreachable [0]
    output logic             o_m_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [13:0] i_cfg_data
);
    import tlik_pkg::*;

    localparam logic [1:0] CFG_UPPER = 2'd0;
    localparam logic [1:0] CFG_FORE  = 2'd1;
    localparam logic [1:0] CFG_TOOL  = 2'd2;

    localparam logic signed [ZW:0] DEG90  = 28'sd5898240;
    localparam logic signed [ZW:0] DEG180 = 28'sd11796480;

    typedef struct packed {
        logic signed [16:0] by;
        logic signed [16:0] bz;
        logic signed [14:0] px;
        logic signed [14:0] py;
        logic signed [31:0] n1;
        logic signed [31:0] n2;
        logic               op;
        logic               unr;
    } t_side_a;

    typedef struct packed {
        logic op;
        logic unr;
    } t_side_b;

    // Rounds 2^-16 degree units to hundredths, half up.
    function automatic logic signed [19:0] to_cent(input logic signed [ZW:0] z);
        logic signed [35:0] t;
        t = {{(36 - ZW - 1){z[ZW]}}, z} * 36'sd100 + 36'sd32768;
        return t[35:16];
    endfunction

    logic [13:0] r_l1;
    logic [13:0] r_l2;
    logic [13:0] r_l3;

    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= 14'd2000;
            r_l2 <= 14'd1200;
            r_l3 <= 14'd1300;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_UPPER: r_l1 <= i_cfg_data;
                CFG_FORE:  r_l2 <= i_cfg_data;
                CFG_TOOL:  r_l3 <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // Stage 1: wrist point and link squares.
    logic signed [14:0] in_px, in_py, in_pz;
    logic signed [16:0] py_e, pz_e, l3_e;
    logic               r1_v, r1_op;
    logic signed [14:0] r1_px, r1_py;
    logic signed [16:0] r1_by, r1_bz;
    logic [27:0]        r1_l1sq, r1_l2sq;
    logic [14:0]        r1_sum;
    logic signed [14:0] r1_dif;

    assign in_px = i_s_tdata[14:0];
    assign in_py = i_s_tdata[29:15];
    assign in_pz = i_s_tdata[44:30];
    assign py_e  = {{2{in_py[14]}}, in_py};
    assign pz_e  = {{2{in_pz[14]}}, in_pz};
    assign l3_e  = {3'b000, r_l3};

    // Stage 2: squared distance and annulus bounds.
    logic signed [33:0] byq, bzq;
    logic signed [29:0] dq;
    logic               r2_v, r2_op;
    logic signed [14:0] r2_px, r2_py;
    logic signed [16:0] r2_by, r2_bz;
    logic [27:0]        r2_l1sq, r2_l2sq;
    logic [31:0]        r2_lp;
    logic [29:0]        r2_hi, r2_lo;

    assign byq = r1_by * r1_by;
    assign bzq = r1_bz * r1_bz;
    assign dq  = r1_dif * r1_dif;

    // Stage 3: reach test, cosine law numerators and denominators.
    logic [57:0]        p1;
    logic [55:0]        p2;
    logic               r3_v, r3_op, r3_unr;
    logic signed [14:0] r3_px, r3_py;
    logic signed [16:0] r3_by, r3_bz;
    logic signed [31:0] r3_n1, r3_n2;
    logic [59:0]        r3_d1, r3_d2;

    assign p1 = 58'(r2_l1sq) * 58'(r2_lp[29:0]);
    assign p2 = 56'(r2_l1sq) * 56'(r2_l2sq);

    // Stage 4: numerator squares.
    logic signed [63:0] n1q, n2q;
    logic               r4_v, r4_op, r4_unr;
    logic signed [14:0] r4_px, r4_py;
    logic signed [16:0] r4_by, r4_bz;
    logic signed [31:0] r4_n1, r4_n2;
    logic [59:0]        r4_d1, r4_d2;
    logic [61:0]        r4_n1q, r4_n2q;

    assign n1q = r3_n1 * r3_n1;
    assign n2q = r3_n2 * r3_n2;

    // Stage 5: radicands for the opposite sides of the acos triangles.
    logic               r5_v;
    t_side_a            r5_side;
    logic [59:0]        r5_rad1, r5_rad2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_s_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op   <= i_s_tuser;
            r1_px   <= in_px;
            r1_py   <= in_py;
            r1_by   <= i_s_tuser ? py_e : py_e - l3_e;
            r1_bz   <= i_s_tuser ? pz_e + l3_e : pz_e;
            r1_l1sq <= 28'(r_l1) * 28'(r_l1);
            r1_l2sq <= 28'(r_l2) * 28'(r_l2);
            r1_sum  <= {1'b0, r_l1} + {1'b0, r_l2};
            r1_dif  <= $signed({1'b0, r_l1}) - $signed({1'b0, r_l2});

            r2_op   <= r1_op;
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_by   <= r1_by;
            r2_bz   <= r1_bz;
            r2_l1sq <= r1_l1sq;
            r2_l2sq <= r1_l2sq;
            r2_lp   <= byq[31:0] + bzq[31:0];
            r2_hi   <= 30'(r1_sum) * 30'(r1_sum);
            r2_lo   <= dq[29:0];

            r3_op   <= r2_op;
            r3_px   <= r2_px;
            r3_py   <= r2_py;
            r3_by   <= r2_by;
            r3_bz   <= r2_bz;
            r3_unr  <= (r2_lp >= {2'b00, r2_hi}) || (r2_lp <= {2'b00, r2_lo});
            r3_n1   <= $signed({4'b0000, r2_l1sq} + r2_lp - {4'b0000, r2_l2sq});
            r3_n2   <= $signed({4'b0000, r2_l1sq} + {4'b0000, r2_l2sq} - r2_lp);
            r3_d1   <= {p1, 2'b00};
            r3_d2   <= {2'b00, p2, 2'b00};

            r4_op   <= r3_op;
            r4_px   <= r3_px;
            r4_py   <= r3_py;
            r4_by   <= r3_by;
            r4_bz   <= r3_bz;
            r4_unr  <= r3_unr;
            r4_n1   <= r3_n1;
            r4_n2   <= r3_n2;
            r4_d1   <= r3_d1;
            r4_d2   <= r3_d2;
            r4_n1q  <= n1q[61:0];
            r4_n2q  <= n2q[61:0];

            r5_side.by  <= r4_by;
            r5_side.bz  <= r4_bz;
            r5_side.px  <= r4_px;
            r5_side.py  <= r4_py;
            r5_side.n1  <= r4_n1;
            r5_side.n2  <= r4_n2;
            r5_side.op  <= r4_op;
            r5_side.unr <= r4_unr;
            r5_rad1 <= ({2'b00, r4_d1} > r4_n1q) ? 60'({2'b00, r4_d1} - r4_n1q) : '0;
            r5_rad2 <= ({2'b00, r4_d2} > r4_n2q) ? 60'({2'b00, r4_d2} - r4_n2q) : '0;
        end
    end

    // Square root chains, with the side data delayed alongside them.
    logic [SQ_ROOT_W-1:0] root1, root2;
    t_side_a              r_la [SQ_LAT];
    logic [SQ_LAT-1:0]    r_la_v;

    tlik_sqrt u_sqrt_beta (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r5_rad1),
        .o_root (root1)
    );

    tlik_sqrt u_sqrt_gamma (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r5_rad2),
        .o_root (root2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_la_v <= '0;
        end else if (en) begin
            r_la_v <= {r_la_v[SQ_LAT-2:0], r5_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_la[0] <= r5_side;
            for (int k = 1; k < SQ_LAT; k++) begin
                r_la[k] <= r_la[k-1];
            end
        end
    end

    // Four arctangent chains run side by side.
    t_side_a              sa;
    logic signed [ZW-1:0] z_alpha, z_beta, z_gamma, z_yaw;

    assign sa = r_la[SQ_LAT-1];

    tlik_cordic u_cordic_alpha (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   ({{(CW - 17){sa.bz[16]}}, sa.bz}),
        .i_x   ({{(CW - 17){sa.by[16]}}, sa.by}),
        .o_z   (z_alpha)
    );

    tlik_cordic u_cordic_beta (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   ({{(CW - SQ_ROOT_W){1'b0}}, root1}),
        .i_x   ({{(CW - 32){sa.n1[31]}}, sa.n1}),
        .o_z   (z_beta)
    );

    tlik_cordic u_cordic_gamma (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   ({{(CW - SQ_ROOT_W){1'b0}}, root2}),
        .i_x   ({{(CW - 32){sa.n2[31]}}, sa.n2}),
        .o_z   (z_gamma)
    );

    tlik_cordic u_cordic_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   ({{(CW - 15){sa.px[14]}}, sa.px}),
        .i_x   ({{(CW - 15){sa.py[14]}}, sa.py}),
        .o_z   (z_yaw)
    );

    t_side_b               r_lb [CORDIC_LAT];
    logic [CORDIC_LAT-1:0] r_lb_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lb_v <= '0;
        end else if (en) begin
            r_lb_v <= {r_lb_v[CORDIC_LAT-2:0], r_la_v[SQ_LAT-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lb[0].op  <= sa.op;
            r_lb[0].unr <= sa.unr;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                r_lb[k] <= r_lb[k-1];
            end
        end
    end

    // Rounding stage: angles to hundredths, wrist closes the chain sum.
    t_side_b            sb;
    logic signed [19:0] sh, el, wr, yaw;
    logic signed [15:0] yaw_c;
    logic [70:0]        rd_word;
    logic               r_rv;
    logic [71:0]        r_rd;
    logic               r_ru;

    assign sb = r_lb[CORDIC_LAT-1];

    always_comb begin
        sh  = to_cent({z_alpha[ZW-1], z_alpha} + {z_beta[ZW-1], z_beta} - DEG90);
        el  = to_cent({z_gamma[ZW-1], z_gamma} - DEG180);
        wr  = -sh - el - (sb.op ? 20'sd18000 : 20'sd9000);
        yaw = to_cent({z_yaw[ZW-1], z_yaw});
        if (yaw > 20'sd18000) begin
            yaw_c = 16'sd18000;
        end else if (yaw < -20'sd18000) begin
            yaw_c = -16'sd18000;
        end else begin
            yaw_c = yaw[15:0];
        end
        if (sb.unr) begin
            rd_word = {1'b1, 70'd0};
        end else begin
            rd_word = {1'b0, yaw_c, wr[17:0], el[17:0], sh[17:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (en) begin
            r_rv <= r_lb_v[CORDIC_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd <= {2'b00, rd_word[69:0]};
            r_ru <= rd_word[70];
        end
    end

    // Output register with a one-word skid stage; the pipeline stalls only
    // while the skid word is held.
    logic        r_ov, r_sv;
    logic [71:0] r_od, r_sd;
    logic        r_ou, r_su;

    assign en = !r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || i_m_tready) begin
            r_ov <= r_sv || r_rv;
            r_sv <= 1'b0;
        end else if (r_rv && en) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_m_tready) begin
            r_od <= r_sv ? r_sd : r_rd;
            r_ou <= r_sv ? r_su : r_ru;
        end else if (r_rv && en) begin
            r_sd <= r_rd;
            r_su <= r_ru;
        end
    end

    assign o_s_tready = en;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign o_m_tuser  = r_ou;

endmodule

`default_nettype wire

// ===== tb/tb_two_link_arm_inverse_kinematics_top.sv =====
`default_nettype none

module tb_two_link_arm_inverse_kinematics_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes carried in the slave-side tuser.
    typedef enum logic {OP_GRASP = 1'b0, OP_PLACE = 1'b1} t_op;

    // Configuration register indexes.
    localparam logic [1:0] REG_UPPER_LINK = 2'd0;
    localparam logic [1:0] REG_FORE_LINK  = 2'd1;
    localparam logic [1:0] REG_TOOL       = 2'd2;
    localparam logic [1:0] REG_UNUSED     = 2'd3;

    // The drain wait allows a generous margin over the pipeline depth.
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PER_PHASE = 210;
    localparam longint NORM_MAG = 64'sd1 << 40;

    // One joint solution as it appears on the master stream.
    typedef struct packed {
        logic signed [17:0] shoulder;
        logic signed [17:0] elbow;
        logic signed [17:0] wrist;
        logic signed [15:0] yaw;
        logic               unreachable;
    } t_joints;

    // One directed stimulus row. Rows with typed set carry their expected
    // solution; the others are checked against the predictor.
    typedef struct {
        t_op    op;
        int     x;
        int     y;
        int     z;
        bit     typed;
        t_joints want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // point_x [14:0], point_y [29:15], point_z [44:30], zero pad [47:45]
    logic [47:0] i_s_tdata = '0;
    // operation [0]
    logic        i_s_tuser = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // shoulder_angle [17:0], elbow_angle [35:18], wrist_angle [53:36],
    // base_yaw_angle [69:54], zero pad [71:70]
    logic [71:0] o_m_tdata;
    // unreachable [0]
    logic        o_m_tuser;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [13:0] i_cfg_data = '0;

    two_link_arm_inverse_kinematics_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // The predictor keeps its own copy of the three length registers.
    longint unsigned upper_len, fore_len, tool_len;
    t_joints pending_joints[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // Arctangent of 2^-i in units of 2^-16 degree.
    longint atan_step[32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Vectoring CORDIC arctangent of (y, x) in units of 2^-16 degree.
    function automatic longint vector_angle(longint y, longint x);
        longint z, t, dx, dy;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        while (abs64(x) < NORM_MAG && abs64(y) < NORM_MAG) begin
            x = x * 2;
            y = y * 2;
        end
        // A vector in the left half plane is first turned by 90 degrees.
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t;
                z = 90 * 65536;
            end else begin
                t = x; x = -y; y = t;
                z = -90 * 65536;
            end
        end
        for (int i = 0; i < tlik_pkg::CORDIC_ITERATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += (i < 32) ? atan_step[i] : 0;
            end else begin
                x -= dx; y += dy; z -= (i < 32) ? atan_step[i] : 0;
            end
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Arccosine of num / sqrt(den2), done as an arctangent with exact integers.
    function automatic longint cos_law_angle(longint num, longint unsigned den2);
        longint unsigned n2, s;
        n2 = longint'(num * num);
        s = (den2 > n2) ? int_sqrt(den2 - n2) : 0;
        return vector_angle(longint'(s), num);
    endfunction

    function automatic longint to_centideg(longint z);
        return (z * 100 + 32768) >>> 16;
    endfunction

    function automatic t_joints solve_joints(t_op op, logic [14:0] px_raw,
                                             logic [14:0] py_raw, logic [14:0] pz_raw);
        longint px, py, pz, l1, l2, l3, wy, wz, lp, hi, lo;
        longint sh, el, wr, yaw, alpha, beta, gamma;
        t_joints j;
        px = longint'($signed(px_raw));
        py = longint'($signed(py_raw));
        pz = longint'($signed(pz_raw));
        l1 = longint'(upper_len);
        l2 = longint'(fore_len);
        l3 = longint'(tool_len);
        sh = 0; el = 0; wr = 0; yaw = 0;
        // Grasp offsets the wrist horizontally, place offsets it vertically.
        if (op == OP_GRASP) begin
            wy = py - l3; wz = pz;
        end else begin
            wy = py; wz = pz + l3;
        end
        lp = wy * wy + wz * wz;
        hi = (l1 + l2) * (l1 + l2);
        lo = (l1 - l2) * (l1 - l2);
        j.unreachable = (lp >= hi) || (lp <= lo);
        if (!j.unreachable) begin
            alpha = vector_angle(wz, wy);
            beta  = cos_law_angle(l1 * l1 + lp - l2 * l2,
                                  longint'(4 * l1 * l1) * longint'(lp));
            gamma = cos_law_angle(l1 * l1 + l2 * l2 - lp,
                                  longint'(4 * l1 * l1) * longint'(l2 * l2));
            sh = to_centideg(alpha + beta - 90 * 65536);
            el = to_centideg(gamma - 180 * 65536);
            // The wrist closes the chain from the already rounded joints.
            wr = -sh - el - ((op == OP_GRASP) ? 9000 : 18000);
            yaw = to_centideg(vector_angle(px, py));
            if (yaw > 18000) yaw = 18000;
            if (yaw < -18000) yaw = -18000;
        end
        j.shoulder = sh[17:0];
        j.elbow    = el[17:0];
        j.wrist    = wr[17:0];
        j.yaw      = yaw[15:0];
        return j;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    // Writes one register at a falling edge; the block takes it at the next rise.
    task automatic write_length(logic [1:0] idx, logic [13:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_UPPER_LINK: upper_len = val;
            REG_FORE_LINK:  fore_len = val;
            REG_TOOL:       tool_len = val;
            default: ;
        endcase
    endtask

    // The sender runs in bursts; burst_left counts the words of the current one.
    int burst_left = 0;

    // Drives one word and waits for its acceptance. The word is predicted at
    // the accepting edge unless a typed expectation is given.
    task automatic send_point(t_op op, int x, int y, int z, bit typed, t_joints want);
        int gap;
        logic [14:0] xr, yr, zr;
        xr = x[14:0];
        yr = y[14:0];
        zr = z[14:0];
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= {3'b000, zr, yr, xr};
        do @(posedge i_clk); while (!o_s_tready);
        pending_joints.push_back(typed ? want : solve_joints(op, xr, yr, zr));
    endtask

    // Lowers valid after the last word and waits until every solution is back.
    task automatic drain_pipeline;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_joints.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Most random words put the wrist point in the square spanned by the current
    // reach; the rest are raw 15-bit values, which are mostly unreachable.
    task automatic send_random_point;
        t_op op;
        int reach, wy, wz, y, z;
        op = t_op'($urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0) begin
            reach = int'(upper_len + fore_len);
            if (reach < 1) reach = 1;
            if (reach > 16000) reach = 16000;
            wy = $urandom_range(0, 2 * reach) - reach;
            wz = $urandom_range(0, 2 * reach) - reach;
            y = (op == OP_GRASP) ? wy + int'(tool_len) : wy;
            z = (op == OP_PLACE) ? wz - int'(tool_len) : wz;
            if (y > 16383) y = 16383;
            if (y < -16384) y = -16384;
            if (z > 16383) z = 16383;
            if (z < -16384) z = -16384;
            send_point(op, $urandom_range(0, 32767) - 16384, y, z, 1'b0, '0);
        end else begin
            send_point(op, $urandom_range(0, 32767), $urandom_range(0, 32767),
                       $urandom_range(0, 32767), 1'b0, '0);
        end
    endtask

    task automatic random_phase(logic [13:0] l1, logic [13:0] l2, logic [13:0] l3);
        write_length(REG_UPPER_LINK, l1);
        write_length(REG_FORE_LINK, l2);
        write_length(REG_TOOL, l3);
        repeat (RANDOM_PER_PHASE) send_random_point();
        drain_pipeline();
    endtask

    // The receiver stalls on a pattern in one of four randomly chosen modes:
    // always ready, mostly ready, mostly stalled, and a fixed duty cycle.
    int unsigned stall_mode = 0;
    always @(negedge i_clk) begin
        if (cycle_count % 150 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= ($urandom_range(0, 3) != 0);
            2: i_m_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_tready <= (cycle_count % 5 < 3);
        endcase
    end

    // Result checker: every accepted word is compared with the oldest solution.
    always @(posedge i_clk) begin
        t_joints got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tdata[17:0], o_m_tdata[35:18], o_m_tdata[53:36],
                   o_m_tdata[69:54], o_m_tuser};
            if (pending_joints.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = pending_joints.pop_front();
                if (got.shoulder !== want.shoulder)
                    report_mismatch("shoulder", got.shoulder, want.shoulder);
                if (got.elbow !== want.elbow)
                    report_mismatch("elbow", got.elbow, want.elbow);
                if (got.wrist !== want.wrist)
                    report_mismatch("wrist", got.wrist, want.wrist);
                if (got.yaw !== want.yaw)
                    report_mismatch("base yaw", got.yaw, want.yaw);
                if (got.unreachable !== want.unreachable)
                    report_mismatch("unreachable", got.unreachable, want.unreachable);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL two_link_arm_inverse_kinematics_top");
            $finish;
        end
    end

    // Directed rows for the reset lengths 2000, 1200 and 1300. Points on the
    // annulus boundary, a zero wrist vector and far points are unreachable
    // with all angles zero; the rest go through the predictor.
    localparam t_joints OUT_OF_REACH = '{0, 0, 0, 0, 1'b1};
    t_row directed_rows[] = '{
        '{OP_GRASP,      0,      0,      0, 1'b0, '0},
        '{OP_PLACE,      0,      0,      0, 1'b0, '0},
        '{OP_GRASP,      0,  10000,  10000, 1'b1, OUT_OF_REACH},
        '{OP_PLACE, -16384, -16384, -16384, 1'b1, OUT_OF_REACH},
        '{OP_GRASP,  16383,  16383,  16383, 1'b1, OUT_OF_REACH},
        '{OP_GRASP,      0,   1300,      0, 1'b1, OUT_OF_REACH},
        '{OP_PLACE,      0,      0,  -1300, 1'b1, OUT_OF_REACH},
        '{OP_PLACE,      5,   3200,  -1300, 1'b1, OUT_OF_REACH},
        '{OP_PLACE,      5,    800,  -1300, 1'b1, OUT_OF_REACH},
        '{OP_PLACE,      5,   3199,  -1300, 1'b0, '0},
        '{OP_PLACE,      5,    801,  -1300, 1'b0, '0},
        '{OP_GRASP,  10000,   3000,    500, 1'b0, '0},
        '{OP_GRASP, -10000,   3000,    500, 1'b0, '0},
        '{OP_GRASP,      0,     -1,    200, 1'b0, '0},
        '{OP_PLACE,     -1,  -2000,      0, 1'b0, '0},
        '{OP_PLACE,      1,  -2000,      0, 1'b0, '0},
        '{OP_GRASP,  16383,      0,   2000, 1'b0, '0},
        '{OP_GRASP, -16384,      0,  -2000, 1'b0, '0},
        '{OP_PLACE,      0,   2500,   1000, 1'b0, '0},
        '{OP_GRASP,   -700,   -300,  -1500, 1'b0, '0}
    };

    initial begin
        upper_len = 2000;
        fore_len = 1200;
        tool_len = 1300;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_point(directed_rows[k].op, directed_rows[k].x, directed_rows[k].y,
                       directed_rows[k].z, directed_rows[k].typed, directed_rows[k].want);
        repeat (RANDOM_PER_PHASE) send_random_point();
        drain_pipeline();

        // Smallest lengths, then large ones, then mixed settings.
        random_phase(14'd1, 14'd1, 14'd0);
        random_phase(14'd10000, 14'd10000, 14'd10000);
        random_phase(14'd3000, 14'd500, 14'd800);
        random_phase(14'd500, 14'd3000, 14'd0);
        // A zero link makes every point unreachable; the unused index is ignored.
        write_length(REG_UNUSED, 14'd777);
        random_phase(14'd0, 14'd1200, 14'd1300);
        random_phase(14'd16383, 14'd16383, 14'd16383);
        random_phase(14'($urandom_range(1, 10000)), 14'($urandom_range(1, 10000)),
                     14'($urandom_range(0, 10000)));

        if (mismatches == 0)
            $display("PASS two_link_arm_inverse_kinematics_top");
        else
            $display("FAIL two_link_arm_inverse_kinematics_top");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/tlik_pkg.sv
rtl/tlik_sqrt_cell.sv
rtl/tlik_sqrt.sv
rtl/tlik_cordic_cell.sv
rtl/tlik_cordic.sv
rtl/two_link_arm_inverse_kinematics_top.sv
tb/tb_two_link_arm_inverse_kinematics_top.sv
